@@ sv/abf_pkg.sv @@
// ----------------------------------------------------------------------------
// abf_pkg
// shared types and constants for the alpha blending frame buffer
// ----------------------------------------------------------------------------
package abf_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int X_W         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int Y_W         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int PIX_W  = 32;
	localparam int SIZE_W = 9;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_FILL  = 2'd2
	} req_t;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ACCESS
	} state_t;

	typedef logic [PIX_W-1:0] pixel_t;

endpackage

@@ sv/abf_ram.sv @@
// ----------------------------------------------------------------------------
// abf_ram
// single clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module abf_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 32,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/abf_blend.sv @@
// ----------------------------------------------------------------------------
// abf_blend
// blends a source color over a stored pixel by the source alpha
// ----------------------------------------------------------------------------
module abf_blend
	import abf_pkg::*;
(
	input  pixel_t old_pix,
	input  pixel_t src_pix,
	output pixel_t new_pix
);

	logic [7:0] alpha;
	logic [7:0] inv_alpha;
	logic [7:0] chan [3];
	logic [8:0] alpha_sum;

	assign alpha     = src_pix[31:24];
	assign inv_alpha = 8'd255 - alpha;
	assign alpha_sum = {1'b0, old_pix[31:24]} + {1'b0, alpha};

	always_comb begin
		logic [15:0] s;
		logic [16:0] q;
		for (int c = 0; c < 3; c++) begin
			s = 16'(old_pix[8*c +: 8]) * 16'(inv_alpha) + 16'(src_pix[8*c +: 8]) * 16'(alpha);
			// exact floor(s / 255) for any s up to 255*255, the largest sum here
			q = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
			chan[c] = q[15:8];
		end
	end

	// full alpha replaces the pixel outright
	assign new_pix = (alpha == 8'd255) ? src_pix
		: {alpha_sum[8:1], chan[2], chan[1], chan[0]};

endmodule

@@ sv/alpha_blend_framebuffer_unit.sv @@
// ----------------------------------------------------------------------------
// alpha_blend_framebuffer_unit
// rgba8888 frame store with blended writes, reads and whole frame fill
// ----------------------------------------------------------------------------
// Pixels live in one synchronous RAM of MAX_WIDTH*MAX_HEIGHT words, pixel
// (x, y) at word y*MAX_WIDTH + x. For a read or write request the RAM is
// read on the accepting edge; a write puts the blended pixel back as the
// request leaves the access state, which waits while a result is unaccepted,
// and the input stays closed in between so that the read-modify-write of
// one word never overlaps another. Every request gives one result
// transaction. A fill gives its result first and then sweeps all
// MAX_WIDTH*MAX_HEIGHT words one word a cycle with no input accepted.
// After reset the same sweep clears the store to zero, so no request is
// accepted before it completes. Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module alpha_blend_framebuffer_unit
	import abf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x[15:0], pos_y[31:16], color_in[63:32]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_out[31:0]
	output logic [0:0]  m_tuser    // hit[0]
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;

	logic [ADDR_W-1:0] sweep_cnt_q;
	pixel_t            fill_color_q;
	logic              sweep_last;

	logic        in_xact;
	logic [15:0] pos_x, pos_y;
	logic        x_ok, y_ok;
	logic [ADDR_W-1:0] in_addr;

	req_t              req_s1;
	logic              inside_s1;
	logic [ADDR_W-1:0] addr_s1;
	pixel_t            color_s1;

	logic   s1_adv;
	pixel_t rd_data;
	pixel_t blend_pix;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	pixel_t            ram_wdata;

	logic   res_hit;
	pixel_t res_pix;
	logic   m_tvalid_q;
	pixel_t m_tdata_q;
	logic   m_tuser_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request decode
	assign in_xact = s_tvalid && s_tready;
	assign pos_x   = s_tdata[15:0];
	assign pos_y   = s_tdata[31:16];

	// oversized frame clamps to the store size
	assign x_ok = !pos_x[15] && ({1'b0, pos_x} < 17'(frame_width_q))
		&& ({1'b0, pos_x} < 17'(MAX_WIDTH));
	assign y_ok = !pos_y[15] && ({1'b0, pos_y} < 17'(frame_height_q))
		&& ({1'b0, pos_y} < 17'(MAX_HEIGHT));

	assign in_addr = ADDR_W'(pos_y[Y_W-1:0] * MAX_WIDTH) + ADDR_W'(pos_x[X_W-1:0]);

	always_ff @(posedge clk) begin
		if (in_xact) begin
			req_s1    <= req_t'(s_tuser);
			inside_s1 <= x_ok && y_ok;
			addr_s1   <= in_addr;
			color_s1  <= s_tdata[63:32];
		end
	end

	// state machine
	assign sweep_last = (sweep_cnt_q == ADDR_W'(STORE_WORDS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = (req_s1 == REQ_FILL) ? ST_SWEEP : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		s1_adv   = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_ACCESS: s1_adv   = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_cnt_q  <= '0;
			fill_color_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			end
			if (s1_adv && req_s1 == REQ_FILL) begin
				sweep_cnt_q  <= '0;
				fill_color_q <= color_s1;
			end
		end
	end

	// memory and blend
	abf_blend u_blend (
		.old_pix (rd_data),
		.src_pix (color_s1),
		.new_pix (blend_pix)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = blend_pix;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = fill_color_q;
		end else if (s1_adv && req_s1 == REQ_WRITE && inside_s1
				&& color_s1[31:24] != 8'd0) begin
			ram_we = 1'b1;
		end
	end

	abf_ram #(
		.DEPTH (STORE_WORDS),
		.WIDTH (PIX_W),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_xact),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	// result
	always_comb begin
		res_hit = 1'b0;
		res_pix = '0;
		case (req_s1)
			REQ_WRITE: res_hit = inside_s1;
			REQ_READ: begin
				res_hit = inside_s1;
				res_pix = inside_s1 ? rd_data : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_tdata_q <= res_pix;
			m_tuser_q <= res_hit;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// checks
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |-> !ram_we)
		else $error("ram written in the cycle a request is accepted");

	a_accept_to_access: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> (state_q == ST_ACCESS))
		else $error("accepted request did not enter the access state");

	a_miss_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("missed request returned a nonzero pixel");

	a_sweep_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SWEEP) |-> (sweep_cnt_q == '0))
		else $error("fill sweep did not start at word zero");

endmodule
